@@ sv/epr_pkg.sv @@
// ----------------------------------------------------------------------------
// epr_pkg
// Shared types and constants for the echo pulse range meter.
// ----------------------------------------------------------------------------
package epr_pkg;

  // field widths
  localparam int unsigned TsW      = 16;  // timestamp field
  localparam int unsigned CfgW     = 16;  // config registers
  localparam int unsigned WidthW   = 16;  // accepted pulse width (< timeout)
  localparam int unsigned TenthsW  = 14;
  localparam int unsigned CmW      = 11;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned StampBitsDefault = 16;

  // tuser bit positions on the input side
  localparam int unsigned UserCmdBit  = 0;
  localparam int unsigned UserEdgeBit = 1;

  // command codes
  localparam logic CmdEdge = 1'b0;
  localparam logic CmdTick = 1'b1;

  // register indexes
  localparam logic RegPeriod  = 1'b0;
  localparam logic RegTimeout = 1'b1;

  localparam logic [CfgW-1:0] PeriodReset  = 16'd20000;
  localparam logic [CfgW-1:0] TimeoutReset = 16'd20000;

  // rounding offset: (w*10 + 29) / 58
  localparam logic [19:0] Round58 = 20'd29;
  // floor(n/58) = (n * Recip58) >> Shift58, exact for n < 2^20
  localparam logic [20:0] Recip58 = 21'd1157050;
  localparam int unsigned Shift58 = 26;
  // floor(n/10) = (n * Recip10) >> Shift10, exact for n < 2^14
  localparam logic [14:0] Recip10 = 15'd26215;
  localparam int unsigned Shift10 = 18;
  localparam logic [TenthsW-1:0] Round10 = 14'd5;

  localparam int unsigned MaxTenths = 11299;

  typedef struct packed {
    logic              upd;    // width is valid, update held distance
    logic [WidthW-1:0] width;  // pulse width in us
  } epr_meas_t;

endpackage

@@ sv/epr_ctrl.sv @@
// ----------------------------------------------------------------------------
// epr_ctrl
// Config registers, edge/window state and pulse width check; one register
// stage of measurement requests toward the scaler.
// ----------------------------------------------------------------------------
module epr_ctrl #(
  parameter int unsigned STAMP_BITS = epr_pkg::StampBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [epr_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic                      edge_rising_i,
  input  logic [epr_pkg::TsW-1:0]   timestamp_i,
  output logic                      meas_valid_o,
  input  logic                      meas_ready_i,
  output epr_pkg::epr_meas_t        meas_o
);
  import epr_pkg::*;

  // only the low bits of the stamp are kept, at most the field width
  localparam int unsigned SW = (STAMP_BITS < TsW) ? STAMP_BITS : TsW;
  localparam int unsigned DW = WidthW + 2;  // signed wrap arithmetic

  logic [CfgW-1:0] period_q, timeout_q;
  logic [SW-1:0]   rise_q, rise_d, fall_q, fall_d;
  logic            window_q, window_d;
  logic            rdy_q, rdy_d;
  logic            armed_q, armed_d;
  logic            s1_valid_q, s1_valid_d;
  epr_meas_t       s1_q, s1_d;

  logic [SW-1:0]   stamp;
  logic            accept;
  logic [DW-1:0]   w;
  logic            w_ok;

  assign cfg_ready_o = 1'b1;
  assign stamp       = timestamp_i[SW-1:0];
  assign in_ready_o  = !s1_valid_q || meas_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  // width with wrap, two's complement over DW bits
  always_comb begin
    if (fall_q >= rise_q) begin
      w = DW'(fall_q) - DW'(rise_q);
    end else begin
      w = DW'(period_q) - DW'(rise_q) + DW'(fall_q);
    end
  end

  assign w_ok = !w[DW-1] && (w != '0) && (w[DW-2:0] < {1'b0, timeout_q});

  always_comb begin
    rise_d     = rise_q;
    fall_d     = fall_q;
    window_d   = window_q;
    rdy_d      = rdy_q;
    armed_d    = armed_q;
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (in_ready_o) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      unique case (cmd_i)
        CmdEdge: begin
          if (!armed_q) begin
            if (edge_rising_i) begin
              rise_d  = stamp;
              armed_d = 1'b1;
            end
          end else if (!edge_rising_i) begin
            if (window_q) begin
              fall_d   = stamp;
              rdy_d    = 1'b1;
              window_d = 1'b0;
            end
            armed_d = 1'b0;
          end
        end
        CmdTick: begin
          s1_valid_d = 1'b1;
          s1_d.upd   = 1'b0;
          s1_d.width = w[WidthW-1:0];
          if (window_q) begin
            // timeout: drop the window, re-arm rising
            rdy_d   = 1'b0;
            armed_d = 1'b0;
          end else if (rdy_q) begin
            rdy_d    = 1'b0;
            s1_d.upd = w_ok;
          end
          window_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PeriodReset;
      timeout_q  <= TimeoutReset;
      rise_q     <= '0;
      fall_q     <= '0;
      window_q   <= 1'b0;
      rdy_q      <= 1'b0;
      armed_q    <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegPeriod:  period_q  <= cfg_data_i;
          RegTimeout: timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      rise_q     <= rise_d;
      fall_q     <= fall_d;
      window_q   <= window_d;
      rdy_q      <= rdy_d;
      armed_q    <= armed_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign meas_valid_o = s1_valid_q;
  assign meas_o       = s1_q;

endmodule

@@ sv/epr_dist.sv @@
// ----------------------------------------------------------------------------
// epr_dist
// Width to tenths of a cm by reciprocal multiply; owns the held distance.
// ----------------------------------------------------------------------------
module epr_dist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        meas_valid_i,
  output logic                        meas_ready_o,
  input  epr_pkg::epr_meas_t          meas_i,
  output logic                        dist_valid_o,
  input  logic                        dist_ready_i,
  output logic [epr_pkg::TenthsW-1:0] held_o
);
  import epr_pkg::*;

  logic               s2_valid_q;
  logic [TenthsW-1:0] held_q;
  logic [19:0]        num;
  logic [40:0]        prod;
  logic               load;

  assign meas_ready_o = !s2_valid_q || dist_ready_i;
  assign load         = meas_valid_i && meas_ready_o;

  // w*10 + 29 as shift-add
  assign num  = (20'(meas_i.width) << 3) + (20'(meas_i.width) << 1) + Round58;
  assign prod = 41'(num) * 41'(Recip58);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      held_q     <= '0;
    end else begin
      if (meas_ready_o) begin
        s2_valid_q <= meas_valid_i;
      end
      if (load && meas_i.upd) begin
        held_q <= prod[Shift58 +: TenthsW];
      end
    end
  end

  assign dist_valid_o = s2_valid_q;
  assign held_o       = held_q;

endmodule

@@ sv/epr_out.sv @@
// ----------------------------------------------------------------------------
// epr_out
// Output register: captures tenths and rounds to whole cm.
// ----------------------------------------------------------------------------
module epr_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        dist_valid_i,
  output logic                        dist_ready_o,
  input  logic [epr_pkg::TenthsW-1:0] held_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [epr_pkg::TenthsW-1:0] tenths_o,
  output logic [epr_pkg::CmW-1:0]     cm_o
);
  import epr_pkg::*;

  logic               valid_q;
  logic [TenthsW-1:0] tenths_q;
  logic [CmW-1:0]     cm_q;
  logic [TenthsW-1:0] num;
  logic [28:0]        prod;

  assign dist_ready_o = !valid_q || out_ready_i;

  // (tenths + 5) / 10
  assign num  = held_i + Round10;
  assign prod = 29'(num) * 29'(Recip10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (dist_ready_o) begin
      valid_q <= dist_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_ready_o && dist_valid_i) begin
      tenths_q <= held_i;
      cm_q     <= prod[Shift10 +: CmW];
    end
  end

  assign out_valid_o = valid_q;
  assign tenths_o    = tenths_q;
  assign cm_o        = cm_q;

endmodule

@@ sv/echo_pulse_range_meter.sv @@
// ----------------------------------------------------------------------------
// echo_pulse_range_meter
// Echo pulse width to distance, reported on every process tick.
// ----------------------------------------------------------------------------
// Input requests are echo edges (tuser[0]=0) or process ticks (tuser[0]=1).
// Edges alternate rising/falling; a falling edge counts only inside an open
// window. Each tick closes the window (timeout) or turns a captured pulse
// into a distance, emits one result, and reopens the window. Edges produce
// no result. One request is taken per clock unless the pipeline stalls; a
// tick's result is presented after passing three registers (control
// stage, divide-by-58 multiplier stage, divide-by-10 output register). The
// pipeline stalls only when all three stages hold results that the sink
// has not taken. Config writes are always ready and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module echo_pulse_range_meter #(
  parameter int unsigned STAMP_BITS = epr_pkg::StampBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,  // 0 period, 1 timeout
  input  logic [epr_pkg::CfgW-1:0]     cfg_data_i,
  // request stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [epr_pkg::TsW-1:0]      s_axis_tdata_i,  // [15:0] timestamp_us
  input  logic [epr_pkg::InUserW-1:0]  s_axis_tuser_i,  // [0] cmd, [1] edge_rising
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [13:0] distance_tenths_cm, [24:14] distance_cm, [31:25] zero
  output logic [epr_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import epr_pkg::*;

  logic               meas_valid, meas_ready;
  epr_meas_t          meas;
  logic               dist_valid, dist_ready;
  logic [TenthsW-1:0] held;
  logic [TenthsW-1:0] tenths;
  logic [CmW-1:0]     cm;

  // edge/window state and width check
  epr_ctrl #(
    .STAMP_BITS (STAMP_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .cmd_i         (s_axis_tuser_i[UserCmdBit]),
    .edge_rising_i (s_axis_tuser_i[UserEdgeBit]),
    .timestamp_i   (s_axis_tdata_i),
    .meas_valid_o  (meas_valid),
    .meas_ready_i  (meas_ready),
    .meas_o        (meas)
  );

  // width -> tenths of cm, held distance lives here
  epr_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .meas_valid_i (meas_valid),
    .meas_ready_o (meas_ready),
    .meas_i       (meas),
    .dist_valid_o (dist_valid),
    .dist_ready_i (dist_ready),
    .held_o       (held)
  );

  // round to cm and hold for the sink
  epr_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dist_valid_i (dist_valid),
    .dist_ready_o (dist_ready),
    .held_i       (held),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .tenths_o     (tenths),
    .cm_o         (cm)
  );

  assign m_axis_tdata_o = {(OutDataW - TenthsW - CmW)'(0), cm, tenths};

endmodule

@@ sv/epr_checker.sv @@
// ----------------------------------------------------------------------------
// epr_checker
// Port-level checks for the echo pulse range meter, bound to the top level.
// ----------------------------------------------------------------------------
module epr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [epr_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import epr_pkg::*;

  logic [31:0] tenths_w, cm_w;

  assign tenths_w = 32'(m_axis_tdata_o[TenthsW-1:0]);
  assign cm_w     = 32'(m_axis_tdata_o[TenthsW +: CmW]);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // input only backs up when a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without pending result");

  // tenths stays in range
  a_tenths_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> tenths_w <= MaxTenths)
    else $error("tenths out of range");

  // cm is tenths rounded to nearest
  a_cm_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cm_w * 10 <= tenths_w + 5) && (tenths_w + 5 < cm_w * 10 + 10))
    else $error("cm does not match tenths");

endmodule

bind echo_pulse_range_meter epr_checker u_epr_checker (.*);
